[rtl/assert_macros.svh]
// Assertion helpers shared by the correlator RTL.
// Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define WIC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Plain invariant checked at every clock edge outside reset.
`define WIC_ASSERT_ALWAYS(lbl, cond, msg) \
	`WIC_ASSERT_IMP(lbl, 1'b1, cond, msg)

`endif

[rtl/wic_pkg.sv]
// ----------------------------------------------------------------------------
// wic_pkg
// Shared types and constants of the windowed image correlator.
// ----------------------------------------------------------------------------
`default_nettype none

package wic_pkg;

	localparam int MaxWidth  = 1024;
	localparam int MaxRadius = 7;
	localparam int RingLines = 2 * MaxRadius + 1;
	localparam int ColW      = 10;
	localparam int RowW      = 16;
	localparam int LineW     = 4;
	localparam int AddrW     = LineW + ColW;
	localparam int One       = 16384;

	// window job: raster position of the pixel whose result is due
	typedef struct packed {
		logic [ColW-1:0]  col;
		logic [RowW-1:0]  row;
		logic [LineW-1:0] line;
	} job_t;

	// clamped image geometry
	typedef struct packed {
		logic [2:0]  radius;
		logic [10:0] width;
		logic [15:0] height;
	} geom_t;

	typedef enum logic [1:0] {
		REG_RADIUS = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_GATHER,
		B_ACC,
		B_MUL,
		B_SEARCH,
		B_DONE
	} back_state_t;

endpackage

`default_nettype wire

[rtl/wic_front.sv]
// ----------------------------------------------------------------------------
// wic_front
// Holds the configuration, accepts beats, stores pixel pairs in the line ring, tracks raster
// positions and the pending count, and issues window jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module wic_front import wic_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             mode,
	input  wire logic [7:0]       pixel_first,
	input  wire logic [7:0]       pixel_second,
	input  wire logic             cfg_write,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [15:0]      cfg_data,
	output geom_t                 geom,
	input  wire logic             q_full,
	input  wire logic             q_empty,
	input  wire logic             back_gather,
	output logic                  q_push,
	output job_t                  q_job,
	input  wire logic [AddrW-1:0] rd_addr,
	output logic [15:0]           rd_data
);

	logic [2:0]       radius_q;
	logic [10:0]      width_q;
	logic [15:0]      height_q;
	logic             clr_busy_q;
	logic [AddrW-1:0] clr_addr_q;
	job_t             in_pos_q;
	job_t             out_pos_q;
	logic [12:0]      pending_q;
	logic [15:0]      mem [1 << AddrW];
	logic [15:0]      rd_data_q;
	logic             ready;
	logic             acc;
	logic             emit;
	logic [13:0]      lag;
	logic [13:0]      pending_inc;
	logic             mem_we;
	logic [AddrW-1:0] mem_waddr;
	logic [15:0]      mem_wdata;

	function automatic job_t step_pos(job_t p, geom_t g);
		job_t n;
		n = p;
		if (({1'b0, p.col} + 11'd1) >= g.width) begin
			n.col  = '0;
			n.line = (p.line == LineW'(RingLines - 1)) ? '0 : p.line + 4'd1;
			n.row  = (({1'b0, p.row} + 17'd1) >= {1'b0, g.height}) ? '0 : p.row + 16'd1;
		end else begin
			n.col = p.col + 10'd1;
		end
		return n;
	endfunction

	// clamp the geometry registers
	always_comb begin
		geom.radius = (radius_q == 3'd0) ? 3'd1 : radius_q;
		if (width_q < 11'd3) begin
			geom.width = 11'd3;
		end else if (width_q > 11'(MaxWidth)) begin
			geom.width = 11'(MaxWidth);
		end else begin
			geom.width = width_q;
		end
		geom.height = (height_q < 16'd3) ? 16'd3 : height_q;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 3'd1;
			width_q  <= 11'd1024;
			height_q <= 16'd1024;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_RADIUS: radius_q <= cfg_data[2:0];
				REG_WIDTH:  width_q  <= cfg_data[10:0];
				REG_HEIGHT: height_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// accept: pixel beats wait until no window read is outstanding
	assign ready       = !clr_busy_q && !q_full && (mode || (q_empty && !back_gather));
	assign in_stall    = !ready;
	assign acc         = in_valid && ready;
	assign lag         = 14'(geom.radius) * 14'(geom.width) + 14'(geom.radius);
	assign pending_inc = {1'b0, pending_q} + 14'd1;
	assign emit        = acc && (mode ? (pending_q != '0) : (pending_inc > lag));
	assign q_push      = emit;
	assign q_job       = out_pos_q;

	// advance positions and pending count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pos_q  <= '0;
			out_pos_q <= '0;
			pending_q <= '0;
		end else if (acc) begin
			if (!mode) begin
				in_pos_q <= step_pos(in_pos_q, geom);
			end
			if (emit) begin
				out_pos_q <= step_pos(out_pos_q, geom);
			end
			pending_q <= pending_q + 13'(!mode) - 13'(emit);
		end
	end

	// sweep the line ring to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign mem_we    = clr_busy_q || (acc && !mode);
	assign mem_waddr = clr_busy_q ? clr_addr_q : {in_pos_q.line, in_pos_q.col};
	assign mem_wdata = clr_busy_q ? 16'd0 : {pixel_first, pixel_second};

	// line ring: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

[rtl/wic_queue.sv]
// ----------------------------------------------------------------------------
// wic_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module wic_queue import wic_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output job_t      head,
	output logic      full,
	output logic      empty
);

	job_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = ent_q[rd_ptr_q];

	// store entries
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_job;
		end
	end

	// move pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	`WIC_ASSERT_IMP(a_no_push_full, push, !full || pop, "job pushed into full queue")
	`WIC_ASSERT_IMP(a_no_pop_empty, pop, !empty, "job popped from empty queue")
	`WIC_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= 2'd2, "queue count overrun")

endmodule

`default_nettype wire

[rtl/wic_back.sv]
// ----------------------------------------------------------------------------
// wic_back
// Runs one window job: sums the window from the line ring, forms the
// variances and covariance on a shared 32x32 multiplier, then finds the
// rounded Q2.14 coefficient bit by bit (border: one, zero variance: zero).
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module wic_back import wic_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire geom_t            geom,
	input  wire logic             q_empty,
	input  wire job_t             q_head,
	output logic                  q_pop,
	output logic                  gathering,
	output logic [AddrW-1:0]      rd_addr,
	input  wire logic [15:0]      rd_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic signed [15:0]    correlation,
	output logic [ColW-1:0]       out_column,
	output logic [RowW-1:0]       out_row
);

	back_state_t      state_q, state_d;
	job_t             job_q;
	logic [3:0]       gx_q, gy_q;
	logic [LineW-1:0] gline_q;
	logic [ColW-1:0]  gcol0_q;
	logic             rd_vld_s1;
	logic [15:0]      s1_q, s2_q;
	logic [23:0]      s11_q, s22_q, s12_q;
	logic [3:0]       mstep_q;
	logic [63:0]      mp_q;
	logic [31:0]      t_q, v1_q, v2_q, cabs_q, odd2_q;
	logic             neg_q;
	logic [63:0]      prod_q, c2_q, lo_q;
	logic [95:0]      tot_q;
	logic [3:0]       bit_q;
	logic [2:0]       sstep_q;
	logic [14:0]      k_q;
	logic [15:0]      res_q;
	logic             ov_q;
	logic [15:0]      corr_q;
	logic [ColW-1:0]  ocol_q;
	logic [RowW-1:0]  orow_q;
	logic [31:0]      ma, mb;
	logic [3:0]       span;
	logic [7:0]       n_w;
	logic             border;
	logic [4:0]       lstart;
	logic [32:0]      c_w;
	logic [14:0]      cand;
	logic [15:0]      odd;
	logic             hit;
	logic [14:0]      k_next;
	logic             load_out;
	logic [7:0]       pa, pb;

	assign span   = {geom.radius, 1'b0};
	assign n_w    = 8'(span + 4'd1) * 8'(span + 4'd1);
	assign border = (q_head.col < ColW'(geom.radius))
		|| ((11'(q_head.col) + 11'(geom.radius)) >= geom.width)
		|| (q_head.row < RowW'(geom.radius))
		|| ((17'(q_head.row) + 17'(geom.radius)) >= {1'b0, geom.height});
	assign lstart = 5'(q_head.line) + 5'(RingLines) - 5'(geom.radius);

	assign q_pop     = (state_q == B_IDLE) && !q_empty;
	assign gathering = (state_q == B_GATHER);
	assign rd_addr   = {gline_q, gcol0_q + ColW'(gx_q)};
	assign pa        = rd_data[15:8];
	assign pb        = rd_data[7:0];

	assign c_w    = {1'b0, t_q} - {1'b0, mp_q[31:0]};
	assign cand   = k_q | (15'd1 << bit_q);
	assign odd    = {cand, 1'b0} - 16'd1;
	assign hit    = (tot_q <= {2'b0, c2_q, 30'b0}) && (cand <= 15'(One));
	assign k_next = hit ? cand : k_q;
	assign load_out = (state_q == B_DONE) && (!ov_q || !out_stall);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE:   if (!q_empty) state_d = border ? B_DONE : B_GATHER;
			B_GATHER: if (gx_q == span && gy_q == span) state_d = B_ACC;
			B_ACC:    state_d = B_MUL;
			B_MUL: begin
				if (mstep_q == 4'd8) begin
					state_d = (v1_q == '0 || v2_q == '0) ? B_DONE : B_SEARCH;
				end
			end
			B_SEARCH: if (sstep_q == 3'd4 && bit_q == '0) state_d = B_DONE;
			B_DONE:   if (load_out) state_d = B_IDLE;
			default:  state_d = B_IDLE;
		endcase
	end

	// multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		if (state_q == B_MUL) begin
			case (mstep_q)
				4'd0: begin ma = 32'(n_w);  mb = 32'(s11_q); end
				4'd1: begin ma = 32'(s1_q); mb = 32'(s1_q);  end
				4'd2: begin ma = 32'(n_w);  mb = 32'(s22_q); end
				4'd3: begin ma = 32'(s2_q); mb = 32'(s2_q);  end
				4'd4: begin ma = 32'(n_w);  mb = 32'(s12_q); end
				4'd5: begin ma = 32'(s1_q); mb = 32'(s2_q);  end
				4'd6: begin ma = v1_q;      mb = v2_q;       end
				4'd7: begin ma = cabs_q;    mb = cabs_q;     end
				default: ;
			endcase
		end else if (state_q == B_SEARCH) begin
			case (sstep_q)
				3'd0: begin ma = 32'(odd);      mb = 32'(odd);      end
				3'd1: begin ma = mp_q[31:0];    mb = prod_q[31:0];  end
				3'd2: begin ma = odd2_q;        mb = prod_q[63:32]; end
				default: ;
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencing counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gx_q      <= '0;
			gy_q      <= '0;
			mstep_q   <= '0;
			sstep_q   <= '0;
			bit_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == B_GATHER);
			case (state_q)
				B_IDLE: begin
					gx_q    <= '0;
					gy_q    <= '0;
					mstep_q <= '0;
				end
				B_GATHER: begin
					if (gx_q == span) begin
						gx_q <= '0;
						gy_q <= gy_q + 4'd1;
					end else begin
						gx_q <= gx_q + 4'd1;
					end
				end
				B_MUL: begin
					mstep_q <= mstep_q + 4'd1;
					sstep_q <= '0;
					bit_q   <= 4'd14;
				end
				B_SEARCH: begin
					if (sstep_q == 3'd4) begin
						sstep_q <= '0;
						bit_q   <= bit_q - 4'd1;
					end else begin
						sstep_q <= sstep_q + 3'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath: window sums, products and search
	always_ff @(posedge clk) begin
		mp_q <= ma * mb;
		if (q_pop) begin
			job_q   <= q_head;
			gline_q <= (lstart >= 5'(RingLines)) ? LineW'(lstart - 5'(RingLines))
				: LineW'(lstart);
			gcol0_q <= q_head.col - ColW'(geom.radius);
			s1_q    <= '0;
			s2_q    <= '0;
			s11_q   <= '0;
			s22_q   <= '0;
			s12_q   <= '0;
			res_q   <= 16'(One);
		end
		if (state_q == B_GATHER && gx_q == span) begin
			gline_q <= (gline_q == LineW'(RingLines - 1)) ? '0 : gline_q + 4'd1;
		end
		if (rd_vld_s1) begin
			s1_q  <= s1_q + 16'(pa);
			s2_q  <= s2_q + 16'(pb);
			s11_q <= s11_q + 24'({8'd0, pa} * {8'd0, pa});
			s22_q <= s22_q + 24'({8'd0, pb} * {8'd0, pb});
			s12_q <= s12_q + 24'({8'd0, pa} * {8'd0, pb});
		end
		if (state_q == B_MUL) begin
			case (mstep_q)
				4'd1, 4'd3, 4'd5: t_q <= mp_q[31:0];
				4'd2: v1_q <= t_q - mp_q[31:0];
				4'd4: v2_q <= t_q - mp_q[31:0];
				4'd6: begin
					neg_q  <= c_w[32];
					cabs_q <= c_w[32] ? 32'(-c_w) : c_w[31:0];
				end
				4'd7: prod_q <= mp_q;
				4'd8: begin
					c2_q  <= mp_q;
					k_q   <= '0;
					res_q <= '0;
				end
				default: ;
			endcase
		end
		if (state_q == B_SEARCH) begin
			case (sstep_q)
				3'd1: odd2_q <= mp_q[31:0];
				3'd2: lo_q <= mp_q;
				3'd3: tot_q <= {mp_q, 32'b0} + 96'(lo_q);
				3'd4: begin
					k_q   <= k_next;
					res_q <= neg_q ? (16'd0 - 16'(k_next)) : 16'(k_next);
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (load_out) begin
			ov_q <= 1'b1;
		end else if (!out_stall) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			corr_q <= res_q;
			ocol_q <= job_q.col;
			orow_q <= job_q.row;
		end
	end

	assign out_valid   = ov_q;
	assign correlation = $signed(corr_q);
	assign out_column  = ocol_q;
	assign out_row     = orow_q;

	`WIC_ASSERT_IMP(a_corr_range, ov_q,
		($signed(corr_q) <= 16'sd16384) && ($signed(corr_q) >= -16'sd16384),
		"correlation outside Q2.14 unit range")
	`WIC_ASSERT_IMP(a_k_bound, state_q == B_SEARCH, k_q <= 15'(One),
		"search estimate above one")
	`WIC_ASSERT_IMP(a_read_drained, state_q == B_MUL, !rd_vld_s1,
		"window read still in flight during arithmetic")

endmodule

`default_nettype wire

[rtl/windowed_image_correlation.sv]
// ----------------------------------------------------------------------------
// windowed_image_correlation
// Input (in_valid/in_stall): a pixel pair of two 8-bit images (mode 0) or a
// flush tick (mode 1) that drains one pending result.
// Output (out_valid/out_stall): Q2.14 correlation with its column and row,
// in raster order, radius*width+radius pixel beats behind the input.
// Configuration: cfg_write with cfg_index (0 radius, 1 width, 2 height) and
// cfg_data; write only while no result is in flight.
// Timing: a beat that raises no result is taken each cycle while no window
// read is outstanding. At an interior pixel the back reads the window
// through the single line-ring port, then runs 9 multiply steps and, unless
// a variance is zero, 15 search steps on the shared 32x32 multiplier; at a
// border pixel it goes straight to its result. The result is valid in the
// cycle after the back finishes with a job. A pixel beat waits while a job is
// queued or a window is being read, so results come no faster than the back.
// Reset: the line ring's 16384 words are swept to zero with in_stall
// high; configuration returns to radius 1, 1024 x 1024.
// A stalled receiver holds the output register and the back; flush beats
// then fill the two-entry job queue before the input stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_image_correlation import wic_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               mode,
	input  wire logic [7:0]         pixel_first,
	input  wire logic [7:0]         pixel_second,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      correlation,
	output logic [ColW-1:0]         out_column,
	output logic [RowW-1:0]         out_row,
	input  wire logic               cfg_write,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);

	geom_t            geom;
	logic             q_full;
	logic             q_empty;
	logic             q_push;
	logic             q_pop;
	job_t             q_job;
	job_t             q_head;
	logic             gathering;
	logic [AddrW-1:0] rd_addr;
	logic [15:0]      rd_data;

	wic_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.pixel_first  (pixel_first),
		.pixel_second (pixel_second),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.geom         (geom),
		.q_full       (q_full),
		.q_empty      (q_empty),
		.back_gather  (gathering),
		.q_push       (q_push),
		.q_job        (q_job),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data)
	);

	wic_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.pop      (q_pop),
		.head     (q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	wic_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.geom        (geom),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.gathering   (gathering),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.correlation (correlation),
		.out_column  (out_column),
		.out_row     (out_row)
	);

endmodule

`default_nettype wire
